FILE: src/box_frustum_cull_core_assert.svh
// ============================================================================
// box_frustum_cull_core_assert.svh
// Assertion macros for the chunk box culling core.
// ============================================================================
`ifndef BOX_FRUSTUM_CULL_CORE_ASSERT_SVH
`define BOX_FRUSTUM_CULL_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge.
`define BFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfc assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfc assertion failed");

`else

`define BFC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/bfc_pkg.sv
// ============================================================================
// bfc_pkg
// Shared types, widths and codes of the chunk box culling core.
// ============================================================================
package bfc_pkg;

    // Geometry and table shape
    localparam int CHUNK_WIDTH  = 32;
    localparam int PLANE_COUNT  = 6;
    localparam int ORTHO_PLANES = 4;
    localparam int COEF_COUNT   = 4;

    // Field widths
    localparam int COEF_W      = 32;
    localparam int COORD_W     = 16;
    localparam int HEIGHT_W    = 9;
    localparam int PLANE_IDX_W = 3;
    localparam int COEF_IDX_W  = 2;

    // Derived arithmetic widths
    localparam int POS_W   = COORD_W + $clog2(CHUNK_WIDTH) + 1;
    localparam int SPAN    = CHUNK_WIDTH + 1;
    localparam int SPAN_W  = $clog2(SPAN) + 2;
    localparam int XPROD_W = COEF_W + POS_W;
    localparam int YPROD_W = COEF_W + HEIGHT_W + 1;
    localparam int SPROD_W = COEF_W + SPAN_W;
    localparam int SUM_W   = XPROD_W + 3;

    // Configuration port
    localparam int REG_COUNT = 1;
    localparam int ADDR_W    = $clog2(4 * REG_COUNT) + 1;
    localparam int DATA_W    = 32;
    localparam logic REG_ORTHO_MODE = 1'b0;

    // Item kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    // Coefficient codes
    localparam logic [COEF_IDX_W-1:0] COEF_X = 2'd0;
    localparam logic [COEF_IDX_W-1:0] COEF_Y = 2'd1;
    localparam logic [COEF_IDX_W-1:0] COEF_Z = 2'd2;
    localparam logic [COEF_IDX_W-1:0] COEF_D = 2'd3;

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        coef_t a;
        coef_t b;
        coef_t c;
        coef_t d;
    } plane_t;

    typedef plane_t [PLANE_COUNT-1:0] plane_set_t;

    typedef struct packed {
        logic                        req_type;
        logic [PLANE_IDX_W-1:0]      plane_index;
        logic [COEF_IDX_W-1:0]       coef_index;
        logic signed [COEF_W-1:0]    coef_value;
        logic signed [COORD_W-1:0]   chunk_p;
        logic signed [COORD_W-1:0]   chunk_q;
        logic [HEIGHT_W-1:0]         min_height;
        logic [HEIGHT_W-1:0]         max_height;
    } in_word_t;

    typedef struct packed {
        logic result_kind;
        logic visible;
    } out_word_t;

    // Box corner origin and height range of one test
    typedef struct packed {
        logic signed [POS_W-1:0] x0;
        logic signed [POS_W-1:0] z0;
        logic [HEIGHT_W-1:0]     ylo;
        logic [HEIGHT_W-1:0]     yhi;
    } box_t;

    // Stage advance strobes shared by the pipeline
    typedef struct packed {
        logic adv1;
        logic adv2;
    } pipe_ctrl_t;

endpackage

FILE: src/box_frustum_cull_core.sv
// ============================================================================
// box_frustum_cull_core: chunk bounding box test against six clip planes
// Pipeline: input register, per-plane products, per-plane partial sums, result register.
// Throughput: one word per cycle, unless a held result (rsp_stall) has filled every stage.
// Reset: rst_n clears valids, ortho_mode and all plane coefficients to zero.
// ============================================================================
`include "box_frustum_cull_core_assert.svh"

module box_frustum_cull_core (
    input  logic                           clk,
    input  logic                           rst_n,

    // Request channel
    input  logic                           req_valid,
    output logic                           req_stall,
    input  bfc_pkg::in_word_t              req_word,

    // Response channel
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output bfc_pkg::out_word_t             rsp_word,

    // Configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bfc_pkg::ADDR_W-1:0]     paddr,
    input  logic [bfc_pkg::DATA_W-1:0]     pwdata,
    output logic [bfc_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    // ------------------------------------------------------------------
    // Configuration: one register, ortho_mode, at byte address 0.
    // Address bit 2 selects the register word; anything beyond is ignored.
    // ------------------------------------------------------------------
    logic ortho_reg;
    logic cfg_write;
    logic cfg_hit;

    assign pready    = 1'b1;
    assign cfg_hit   = (paddr[bfc_pkg::ADDR_W-1] == bfc_pkg::REG_ORTHO_MODE);
    assign cfg_write = psel && penable && pwrite && pready && cfg_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ortho_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            ortho_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_hit)
        begin
            prdata[0] = ortho_reg;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. Each stage advances when the one after it is
    // empty or moving, so bubbles close up and a held result stalls the
    // input only once every stage holds a word.
    //   stage 0: input register
    //   stage 1: per-plane products (plane table read here, loads write here)
    //   stage 2: per-plane partial sums
    //   stage 3: result register
    // ------------------------------------------------------------------
    logic                 v0_reg, v1_reg, v2_reg, v3_reg;
    logic                 ready0, ready1, ready2, ready3;
    logic                 req_accept;
    bfc_pkg::pipe_ctrl_t  ctrl;
    bfc_pkg::in_word_t    w0_reg;
    logic                 kind1_reg, kind2_reg;
    bfc_pkg::out_word_t   out_reg, out_next;

    assign ready3     = !v3_reg || !rsp_stall;
    assign ready2     = !v2_reg || ready3;
    assign ready1     = !v1_reg || ready2;
    assign ready0     = !v0_reg || ready1;
    assign req_stall  = !ready0;
    assign req_accept = req_valid && ready0;
    assign ctrl.adv1  = v0_reg && ready1;
    assign ctrl.adv2  = v1_reg && ready2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready0)
            begin
                v0_reg <= req_valid;
            end
            if (ready1)
            begin
                v1_reg <= v0_reg;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload registers: load on advance, no reset.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            w0_reg <= req_word;
        end
        if (ctrl.adv1)
        begin
            kind1_reg <= w0_reg.req_type;
        end
        if (ctrl.adv2)
        begin
            kind2_reg <= kind1_reg;
        end
        if (v2_reg && ready3)
        begin
            out_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Plane table. A load writes as it leaves stage 0, so a test right
    // behind it reads the new coefficient.
    // ------------------------------------------------------------------
    bfc_pkg::plane_set_t planes;
    logic                table_wr;

    assign table_wr = ctrl.adv1 && (w0_reg.req_type == bfc_pkg::REQ_LOAD);

    bfc_plane_table u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (table_wr),
        .plane_index (w0_reg.plane_index),
        .coef_index  (w0_reg.coef_index),
        .coef_value  (w0_reg.coef_value),
        .planes      (planes)
    );

    // ------------------------------------------------------------------
    // Box origin: x0 = p*CHUNK_WIDTH - 1, z0 likewise. The far corner
    // adds CHUNK_WIDTH+1, handled per plane by the span product.
    // ------------------------------------------------------------------
    localparam logic signed [bfc_pkg::POS_W-1:0] CW_S  =
        bfc_pkg::POS_W'(bfc_pkg::CHUNK_WIDTH);
    localparam logic signed [bfc_pkg::POS_W-1:0] ONE_S = bfc_pkg::POS_W'(1);

    bfc_pkg::box_t box;

    always_comb
    begin
        box.x0  = bfc_pkg::POS_W'(w0_reg.chunk_p) * CW_S - ONE_S;
        box.z0  = bfc_pkg::POS_W'(w0_reg.chunk_q) * CW_S - ONE_S;
        box.ylo = w0_reg.min_height;
        box.yhi = w0_reg.max_height;
    end

    // ------------------------------------------------------------------
    // One evaluator per plane; each flags its plane as rejecting.
    // ------------------------------------------------------------------
    logic [bfc_pkg::PLANE_COUNT-1:0] outside;
    logic [bfc_pkg::PLANE_COUNT-1:0] plane_mask;

    for (genvar g = 0; g < bfc_pkg::PLANE_COUNT; g++)
    begin : g_plane
        bfc_plane_eval u_eval (
            .clk     (clk),
            .ctrl    (ctrl),
            .plane   (planes[g]),
            .box     (box),
            .outside (outside[g])
        );
    end

    // Orthographic mode drops the near and far planes.
    always_comb
    begin
        for (int i = 0; i < bfc_pkg::PLANE_COUNT; i++)
        begin
            plane_mask[i] = !ortho_reg || (i < bfc_pkg::ORTHO_PLANES);
        end
        out_next.result_kind = kind2_reg;
        out_next.visible     = (kind2_reg == bfc_pkg::REQ_TEST) &&
                               !(|(outside & plane_mask));
    end

    assign rsp_valid = v3_reg;
    assign rsp_word  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BFC_ASSERT_NOW(a_load_not_visible, clk, rst_n, rsp_valid && (rsp_word.result_kind == bfc_pkg::REQ_LOAD), !rsp_word.visible)
    `BFC_ASSERT_NEXT(a_accept_fills_input, clk, rst_n, req_valid && !req_stall, v0_reg)
    `BFC_ASSERT_NEXT(a_stage2_holds, clk, rst_n, v2_reg && !ready3, v2_reg && $stable(kind2_reg))

endmodule

FILE: src/bfc_plane_table.sv
// ============================================================================
// bfc_plane_table
// Six clip planes of four coefficients each, written one coefficient a time.
// ============================================================================
module bfc_plane_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [bfc_pkg::PLANE_IDX_W-1:0]     plane_index,
    input  logic [bfc_pkg::COEF_IDX_W-1:0]      coef_index,
    input  bfc_pkg::coef_t                      coef_value,
    output bfc_pkg::plane_set_t                 planes
);

    bfc_pkg::coef_t coef_reg [bfc_pkg::PLANE_COUNT][bfc_pkg::COEF_COUNT];

    // Out-of-range plane indexes match no row and write nothing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfc_pkg::PLANE_COUNT; i++)
            begin
                for (int k = 0; k < bfc_pkg::COEF_COUNT; k++)
                begin
                    coef_reg[i][k] <= '0;
                end
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < bfc_pkg::PLANE_COUNT; i++)
            begin
                for (int k = 0; k < bfc_pkg::COEF_COUNT; k++)
                begin
                    if (plane_index == bfc_pkg::PLANE_IDX_W'(i) &&
                        coef_index == bfc_pkg::COEF_IDX_W'(k))
                    begin
                        coef_reg[i][k] <= coef_value;
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < bfc_pkg::PLANE_COUNT; i++)
        begin
            planes[i].a = coef_reg[i][bfc_pkg::COEF_X];
            planes[i].b = coef_reg[i][bfc_pkg::COEF_Y];
            planes[i].c = coef_reg[i][bfc_pkg::COEF_Z];
            planes[i].d = coef_reg[i][bfc_pkg::COEF_D];
        end
    end

endmodule

FILE: src/bfc_plane_eval.sv
// ============================================================================
// bfc_plane_eval
// Largest signed distance of a box corner from one plane, in two stages.
// ============================================================================
module bfc_plane_eval (
    input  logic                 clk,
    input  bfc_pkg::pipe_ctrl_t  ctrl,
    input  bfc_pkg::plane_t      plane,
    input  bfc_pkg::box_t        box,
    output logic                 outside
);

    localparam logic signed [bfc_pkg::SPAN_W-1:0] SPAN_S = bfc_pkg::SPAN_W'(bfc_pkg::SPAN);

    // Stage 1: products
    logic signed [bfc_pkg::XPROD_W-1:0] ax0_reg, ax0_next;
    logic signed [bfc_pkg::XPROD_W-1:0] cz0_reg, cz0_next;
    logic signed [bfc_pkg::SPROD_W-1:0] aspan_reg, aspan_next;
    logic signed [bfc_pkg::SPROD_W-1:0] cspan_reg, cspan_next;
    logic signed [bfc_pkg::YPROD_W-1:0] bylo_reg, bylo_next;
    logic signed [bfc_pkg::YPROD_W-1:0] byhi_reg, byhi_next;
    bfc_pkg::coef_t                     d_reg;

    // Stage 2: partial sums
    logic signed [bfc_pkg::SUM_W-1:0] t1_reg, t1_next;
    logic signed [bfc_pkg::SUM_W-1:0] t2_reg, t2_next;
    logic signed [bfc_pkg::SUM_W-1:0] ax_max, cz_max, by_max, dist_max;

    assign ax0_next   = plane.a * box.x0;
    assign cz0_next   = plane.c * box.z0;
    assign aspan_next = plane.a * SPAN_S;
    assign cspan_next = plane.c * SPAN_S;
    assign bylo_next  = plane.b * $signed({1'b0, box.ylo});
    assign byhi_next  = plane.b * $signed({1'b0, box.yhi});

    always_ff @(posedge clk)
    begin
        if (ctrl.adv1)
        begin
            ax0_reg   <= ax0_next;
            cz0_reg   <= cz0_next;
            aspan_reg <= aspan_next;
            cspan_reg <= cspan_next;
            bylo_reg  <= bylo_next;
            byhi_reg  <= byhi_next;
            d_reg     <= plane.d;
        end
    end

    // Take the far edge along each axis where it raises the distance.
    always_comb
    begin
        ax_max = bfc_pkg::SUM_W'(ax0_reg);
        if (!aspan_reg[bfc_pkg::SPROD_W-1])
        begin
            ax_max = ax_max + bfc_pkg::SUM_W'(aspan_reg);
        end
        cz_max = bfc_pkg::SUM_W'(cz0_reg);
        if (!cspan_reg[bfc_pkg::SPROD_W-1])
        begin
            cz_max = cz_max + bfc_pkg::SUM_W'(cspan_reg);
        end
        if (byhi_reg > bylo_reg)
        begin
            by_max = bfc_pkg::SUM_W'(byhi_reg);
        end
        else
        begin
            by_max = bfc_pkg::SUM_W'(bylo_reg);
        end
        t1_next = ax_max + bfc_pkg::SUM_W'(d_reg);
        t2_next = cz_max + by_max;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv2)
        begin
            t1_reg <= t1_next;
            t2_reg <= t2_next;
        end
    end

    // Every corner strictly negative when the largest distance is negative.
    assign dist_max = t1_reg + t2_reg;
    assign outside  = dist_max[bfc_pkg::SUM_W-1];

endmodule
